// ===== rtl/core/bres_pkg.sv =====
// shared types, constants and saturation helpers for the bresenham line pixel generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bres_pkg;

  localparam int unsigned SwapBoxDef    = 800;
  localparam int unsigned CanvasSizeDef = 1500;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned DeltaW   = 17;
  localparam int unsigned ErrW     = 19;
  localparam int unsigned PixW     = 11;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned OrgW     = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ScaleW-1:0] ScaleRst = 16'd256;

  typedef enum logic {
    OpLoad = 1'b0,
    OpStep = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScale   = 2'd0,
    CfgOriginX = 2'd1,
    CfgOriginY = 2'd2
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [OrgW-1:0]   org_t;

  localparam coord_t MaxCoord = 16'sh7fff;
  localparam coord_t MinCoord = 16'sh8000;

  // scaled endpoints, before the origin is added
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } pts_t;

  // segment set-up handed to the stepper
  typedef struct packed {
    coord_t                  cur_x;
    coord_t                  cur_y;
    coord_t                  stop_x;
    coord_t                  stop_y;
    logic [DeltaW-1:0]       delta_x;
    logic [DeltaW-1:0]       delta_y;
    logic signed [ErrW-1:0]  err_acc;
    logic                    step_x_neg;
    logic                    step_y_neg;
  } seg_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
    logic            last;
  } pix_t;

  function automatic coord_t sat_17(input logic signed [CoordW:0] v);
    if (v[CoordW] == v[CoordW-1]) return v[CoordW-1:0];
    else return v[CoordW] ? MinCoord : MaxCoord;
  endfunction

  function automatic coord_t sat_25(input logic signed [24:0] v);
    if (v[24:CoordW-1] == {10{v[24]}}) return v[CoordW-1:0];
    else return v[24] ? MinCoord : MaxCoord;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bres_in_if.sv =====
// input channel: valid/ready handshake carrying one command beat
// depends on bres_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bres_in_if;
  logic            valid;
  logic            ready;
  logic            op;
  bres_pkg::coord_t start_x;
  bres_pkg::coord_t start_y;
  bres_pkg::coord_t end_x;
  bres_pkg::coord_t end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bres_out_if.sv =====
// output channel: valid/ready handshake carrying one pixel beat
// depends on bres_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bres_out_if;
  logic                        valid;
  logic                        ready;
  logic [bres_pkg::PixW-1:0]   pixel_x;
  logic [bres_pkg::PixW-1:0]   pixel_y;
  logic                        last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bres_scale.sv =====
// first load stage: four q8.8 multiplies, truncation toward zero, 16-bit saturation
// depends on bres_pkg
`timescale 1ns / 1ps
`default_nettype none

module bres_scale (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire bres_pkg::coord_t              start_x_i,
  input  wire bres_pkg::coord_t              start_y_i,
  input  wire bres_pkg::coord_t              end_x_i,
  input  wire bres_pkg::coord_t              end_y_i,
  input  wire logic [bres_pkg::ScaleW-1:0]   scale_i,
  output bres_pkg::pts_t                     pts_o,
  output logic                               vld_o
);

  bres_pkg::coord_t        map_w [4];
  logic signed [32:0]      prod_w [4];
  logic signed [24:0]      trunc_w [4];
  bres_pkg::coord_t        res_q [4];
  logic                    vld_q;

  assign map_w[0] = start_x_i;
  assign map_w[1] = start_y_i;
  assign map_w[2] = end_x_i;
  assign map_w[3] = end_y_i;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign prod_w[i]  = map_w[i] * $signed({1'b0, scale_i});
    // round toward zero for negative products with a fraction
    assign trunc_w[i] = prod_w[i][32:8] + 25'(prod_w[i][32] && (prod_w[i][7:0] != 8'd0));

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        res_q[i] <= bres_pkg::sat_25(trunc_w[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= load_i;
    end
  end

  assign pts_o.ax = res_q[0];
  assign pts_o.ay = res_q[1];
  assign pts_o.bx = res_q[2];
  assign pts_o.by = res_q[3];
  assign vld_o    = vld_q;

endmodule

`default_nettype wire

// ===== rtl/core/bres_setup.sv =====
// second load stage: origin offset, endpoint swap and bresenham set-up
// depends on bres_pkg
`timescale 1ns / 1ps
`default_nettype none

module bres_setup #(
  parameter int unsigned SWAP_BOX = bres_pkg::SwapBoxDef
) (
  input  wire bres_pkg::pts_t  pts_i,
  input  wire bres_pkg::org_t  origin_x_i,
  input  wire bres_pkg::org_t  origin_y_i,
  output bres_pkg::seg_t       seg_o
);

  localparam bres_pkg::coord_t SwapLim = bres_pkg::coord_t'(SWAP_BOX);

  bres_pkg::coord_t ax0, ay0, bx0, by0;
  bres_pkg::coord_t ax, ay, bx, by;
  logic signed [bres_pkg::CoordW:0] ox, oy;
  logic swap;
  logic [bres_pkg::DeltaW-1:0] dx, dy;

  assign ox = {{(bres_pkg::CoordW + 1 - bres_pkg::OrgW){origin_x_i[bres_pkg::OrgW-1]}},
               origin_x_i};
  assign oy = {{(bres_pkg::CoordW + 1 - bres_pkg::OrgW){origin_y_i[bres_pkg::OrgW-1]}},
               origin_y_i};

  assign ax0 = bres_pkg::sat_17({pts_i.ax[bres_pkg::CoordW-1], pts_i.ax} + ox);
  assign ay0 = bres_pkg::sat_17({pts_i.ay[bres_pkg::CoordW-1], pts_i.ay} + oy);
  assign bx0 = bres_pkg::sat_17({pts_i.bx[bres_pkg::CoordW-1], pts_i.bx} + ox);
  assign by0 = bres_pkg::sat_17({pts_i.by[bres_pkg::CoordW-1], pts_i.by} + oy);

  // first point off the swap box: draw from the other end
  assign swap = (ax0 < 0) || (ax0 > SwapLim) || (ay0 < 0) || (ay0 > SwapLim);

  assign ax = swap ? bx0 : ax0;
  assign ay = swap ? by0 : ay0;
  assign bx = swap ? ax0 : bx0;
  assign by = swap ? ay0 : by0;

  assign dx = (ax > bx) ? 17'({ax[15], ax} - {bx[15], bx}) : 17'({bx[15], bx} - {ax[15], ax});
  assign dy = (ay > by) ? 17'({ay[15], ay} - {by[15], by}) : 17'({by[15], by} - {ay[15], ay});

  assign seg_o.cur_x      = ax;
  assign seg_o.cur_y      = ay;
  assign seg_o.stop_x     = bx;
  assign seg_o.stop_y     = by;
  assign seg_o.delta_x    = dx;
  assign seg_o.delta_y    = dy;
  assign seg_o.err_acc    = $signed({2'b00, dx}) - $signed({2'b00, dy});
  assign seg_o.step_x_neg = !(ax < bx);
  assign seg_o.step_y_neg = !(ay < by);

endmodule

`default_nettype wire

// ===== rtl/core/bres_walk.sv =====
// segment state and one bresenham step per step beat
// depends on bres_pkg
`timescale 1ns / 1ps
`default_nettype none

module bres_walk #(
  parameter int unsigned CANVAS_SIZE = bres_pkg::CanvasSizeDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            seg_vld_i,
  input  wire bres_pkg::seg_t  seg_i,
  input  wire logic            step_i,
  output logic                 push_o,
  output bres_pkg::pix_t       pix_o,
  output logic                 running_o
);

  localparam bres_pkg::coord_t CanvasLim = bres_pkg::coord_t'(CANVAS_SIZE);

  bres_pkg::seg_t seg_q, seg_d;
  logic           running_q, running_d;

  logic                          at_stop, off_canvas, emit;
  logic signed [19:0]            e2, dxs, dys, err_n;
  logic                          mvx, mvy;
  bres_pkg::coord_t              nx, ny;
  logic signed [bres_pkg::CoordW:0] incx, incy;

  function automatic logic outside(input bres_pkg::coord_t x, input bres_pkg::coord_t y);
    return (x <= 0) || (x >= CanvasLim) || (y <= 0) || (y >= CanvasLim);
  endfunction

  assign at_stop    = (seg_q.cur_x == seg_q.stop_x) && (seg_q.cur_y == seg_q.stop_y);
  assign off_canvas = outside(seg_q.cur_x, seg_q.cur_y);
  assign emit       = step_i && running_q && !at_stop && !off_canvas;

  assign e2  = {seg_q.err_acc, 1'b0};
  assign dxs = $signed({3'b000, seg_q.delta_x});
  assign dys = $signed({3'b000, seg_q.delta_y});
  assign mvx = e2 > -dys;
  assign mvy = e2 < dxs;

  assign err_n = {seg_q.err_acc[bres_pkg::ErrW-1], seg_q.err_acc}
                 - (mvx ? dys : 20'sd0) + (mvy ? dxs : 20'sd0);

  assign incx = !mvx ? 17'sd0 : (seg_q.step_x_neg ? -17'sd1 : 17'sd1);
  assign incy = !mvy ? 17'sd0 : (seg_q.step_y_neg ? -17'sd1 : 17'sd1);
  assign nx   = bres_pkg::sat_17({seg_q.cur_x[15], seg_q.cur_x} + incx);
  assign ny   = bres_pkg::sat_17({seg_q.cur_y[15], seg_q.cur_y} + incy);

  always_comb begin
    seg_d     = seg_q;
    running_d = running_q;
    if (seg_vld_i) begin
      seg_d     = seg_i;
      running_d = 1'b1;
    end else if (step_i && running_q) begin
      if (at_stop || off_canvas) begin
        running_d = 1'b0;
      end else begin
        seg_d.cur_x   = nx;
        seg_d.cur_y   = ny;
        seg_d.err_acc = err_n[bres_pkg::ErrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q     <= '0;
      running_q <= 1'b0;
    end else begin
      seg_q     <= seg_d;
      running_q <= running_d;
    end
  end

  assign push_o        = emit;
  assign pix_o.pixel_x = seg_q.cur_x[bres_pkg::PixW-1:0];
  assign pix_o.pixel_y = seg_q.cur_y[bres_pkg::PixW-1:0];
  assign pix_o.last    = ((nx == seg_q.stop_x) && (ny == seg_q.stop_y)) || outside(nx, ny);
  assign running_o     = running_q;

endmodule

`default_nettype wire

// ===== rtl/core/bres_ofifo.sv =====
// two-entry output buffer, decouples the stepper from a stalling receiver
// depends on bres_pkg
`timescale 1ns / 1ps
`default_nettype none

module bres_ofifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bres_pkg::pix_t  data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output bres_pkg::pix_t       data_o
);

  bres_pkg::pix_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop)    rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bresenham_line_pixel_generator.sv =====
// top level of the bresenham line pixel generator
// depends on bres_pkg, bres_in_if, bres_out_if, bres_scale, bres_setup, bres_walk, bres_ofifo
//
// usage
//   in_if carries command beats: op load brings two map points, op step asks for one pixel
//   out_if carries pixel beats (pixel_x, pixel_y, last); a step gives at most one beat
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write scale, origin_x, origin_y while the block is idle
// latency and throughput
//   a step beat's pixel is on out_if in the cycle after it is taken, if the buffer was empty
//   steps are taken one per clock while the buffer has room; a load holds in_if.ready low
//   for the next cycle while the scaled points pass the multiply stage and the set-up stage
//   a step that hits the endpoint or leaves the canvas ends the segment and gives no beat
// reset
//   scale returns to 1.0, origins to zero, no segment is active, the buffer is empty
// stalls
//   a two-beat output buffer keeps taking steps while one pixel waits; with two waiting,
//   in_if.ready drops until the receiver takes one
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_pixel_generator #(
  parameter int unsigned SWAP_BOX    = bres_pkg::SwapBoxDef,
  parameter int unsigned CANVAS_SIZE = bres_pkg::CanvasSizeDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bres_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bres_pkg::CfgDataW-1:0]   cfg_wdata_i,
  bres_in_if.sink                              in_if,
  bres_out_if.source                           out_if
);

  logic [bres_pkg::ScaleW-1:0] scale_q;
  bres_pkg::org_t              origin_x_q, origin_y_q;

  logic            in_acc, load_acc, step_acc;
  logic            ld_pend, full, push, running;
  bres_pkg::pts_t  pts;
  bres_pkg::seg_t  seg;
  bres_pkg::pix_t  pix, pix_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= bres_pkg::ScaleRst;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (bres_pkg::cfg_idx_e'(cfg_idx_i))
        bres_pkg::CfgScale:   scale_q    <= cfg_wdata_i[bres_pkg::ScaleW-1:0];
        bres_pkg::CfgOriginX: origin_x_q <= cfg_wdata_i[bres_pkg::OrgW-1:0];
        bres_pkg::CfgOriginY: origin_y_q <= cfg_wdata_i[bres_pkg::OrgW-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !ld_pend && !full;
  assign in_acc      = in_if.valid && in_if.ready;
  assign load_acc    = in_acc && (in_if.op == bres_pkg::OpLoad);
  assign step_acc    = in_acc && (in_if.op == bres_pkg::OpStep);

  bres_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_acc),
    .start_x_i (in_if.start_x),
    .start_y_i (in_if.start_y),
    .end_x_i   (in_if.end_x),
    .end_y_i   (in_if.end_y),
    .scale_i   (scale_q),
    .pts_o     (pts),
    .vld_o     (ld_pend)
  );

  bres_setup #(
    .SWAP_BOX (SWAP_BOX)
  ) u_setup (
    .pts_i      (pts),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .seg_o      (seg)
  );

  bres_walk #(
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seg_vld_i (ld_pend),
    .seg_i     (seg),
    .step_i    (step_acc),
    .push_o    (push),
    .pix_o     (pix),
    .running_o (running)
  );

  bres_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pix),
    .full_o  (full),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .data_o  (pix_out)
  );

  assign out_if.pixel_x = pix_out.pixel_x;
  assign out_if.pixel_y = pix_out.pixel_y;
  assign out_if.last    = pix_out.last;

  // a load holds off the next beat until its set-up lands
  a_load_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> ld_pend && !in_if.ready)
    else $error("beat taken while load set-up pending");

  // pixels only come from an active segment
  a_push_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> running && step_acc)
    else $error("pixel pushed without an active segment");

  // a pushed pixel is offered on the next cycle
  a_push_offered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_if.valid)
    else $error("pushed pixel not offered");

endmodule

`default_nettype wire

// ===== sim/tb_bresenham_line_pixel_generator.sv =====
// self-checking testbench for the bresenham line pixel generator: directed table, then
// random segments under several gain/origin settings, with random idling on both channels
// depends on bres_pkg, bres_in_if, bres_out_if and the bresenham_line_pixel_generator rtl
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_generator;
  import bres_pkg::*;

  typedef enum logic [1:0] {
    ChkModel,
    ChkNone,
    ChkPix
  } chk_e;

  typedef struct packed {
    op_e    op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    chk_e   chk;
    pix_t   pix;
  } dir_row_t;

  localparam int NumDir       = 25;
  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 250;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 10;
  localparam int SwapBox      = int'(SwapBoxDef);
  localparam int Canvas       = int'(CanvasSizeDef);

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  cfg_idx_e            cfg_idx_i   = CfgScale;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  bres_in_if  in_ch ();
  bres_out_if out_ch ();

  bresenham_line_pixel_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register copies and line walker state
  int gain  = 256;
  int org_x = 0;
  int org_y = 0;
  int cur_x, cur_y, stop_x, stop_y, dlt_x, dlt_y, err;
  bit neg_x, neg_y, seg_active;

  pix_t pixels_due[$];
  int   mismatches = 0;
  int   items_done = 0;
  bit   hold_out   = 1'b0;
  bit   calm_in    = 1'b0;

  dir_row_t dir_tab [NumDir] = '{
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkNone, '0},
    '{OpLoad, 16'sd10, 16'sd10, 16'sd13, 16'sd11, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkPix, '{11'd10, 11'd10, 1'b0}},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkPix, '{11'd12, 11'd11, 1'b1}},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkNone, '0},
    '{OpLoad, 16'sd900, 16'sd20, 16'sd897, 16'sd20, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkPix, '{11'd897, 11'd20, 1'b0}},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkNone, '0},
    '{OpLoad, 16'sd0, 16'sd5, 16'sd5, 16'sd5, ChkModel, '0},
    '{OpStep, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, ChkNone, '0},
    '{OpLoad, 16'sd1, 16'sd1, -16'sd3, -16'sd3, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkPix, '{11'd1, 11'd1, 1'b1}},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkNone, '0},
    '{OpLoad, 16'sd1500, 16'sd1500, 16'sd1499, 16'sd1499, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkPix, '{11'd1499, 11'd1499, 1'b1}},
    '{OpLoad, 16'sd5, 16'sd5, 16'sd5, 16'sd5, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkNone, '0},
    '{OpLoad, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, ChkModel, '0},
    '{OpStep, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, ChkNone, '0},
    '{OpLoad, 16'sd50, 16'sd60, 16'sd45, 16'sd50, ChkModel, '0},
    '{OpStep, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ChkModel, '0},
    '{OpLoad, 16'sd700, 16'sd700, 16'sd710, 16'sd690, ChkModel, '0}
  };

  int phase_gain [NumPhases] = '{256, 0, 65535, 0, 1, 128, 512, 300};
  int phase_ox   [NumPhases] = '{0, 400, 2047, -2048, 100, -50, -2048, 2047};
  int phase_oy   [NumPhases] = '{0, 400, -2048, 2047, 700, 300, -2048, 2047};

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int map_to_screen(coord_t m, int org);
    longint prod;
    prod = longint'(m) * longint'(gain);
    return clamp16(longint'(clamp16(prod / 256)) + longint'(org));
  endfunction

  // rough inverse of the mapping, to aim random segments at the canvas
  function automatic coord_t screen_to_map(int s, int org);
    longint v;
    if (gain == 0) return coord_t'($urandom);
    v = (longint'(s - org) * 256) / longint'(gain);
    return coord_t'(clamp16(v));
  endfunction

  function automatic bit off_canvas(int x, int y);
    return x <= 0 || x >= Canvas || y <= 0 || y >= Canvas;
  endfunction

  function automatic bit trace_line(input op_e op, input coord_t sx, input coord_t sy,
                                    input coord_t ex, input coord_t ey, output pix_t px);
    int ax, ay, bx, by, t, e2;
    px = '0;
    if (op == OpLoad) begin
      ax = map_to_screen(sx, org_x);
      ay = map_to_screen(sy, org_y);
      bx = map_to_screen(ex, org_x);
      by = map_to_screen(ey, org_y);
      if (ax < 0 || ax > SwapBox || ay < 0 || ay > SwapBox) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      cur_x  = ax;
      cur_y  = ay;
      stop_x = bx;
      stop_y = by;
      dlt_x  = (ax > bx) ? ax - bx : bx - ax;
      dlt_y  = (ay > by) ? ay - by : by - ay;
      err    = dlt_x - dlt_y;
      neg_x  = !(ax < bx);
      neg_y  = !(ay < by);
      seg_active = 1'b1;
      return 1'b0;
    end
    if (!seg_active) return 1'b0;
    if ((cur_x == stop_x && cur_y == stop_y) || off_canvas(cur_x, cur_y)) begin
      seg_active = 1'b0;
      return 1'b0;
    end
    px.pixel_x = cur_x[PixW-1:0];
    px.pixel_y = cur_y[PixW-1:0];
    e2 = err * 2;
    if (e2 > -dlt_y) begin
      err   -= dlt_y;
      cur_x += neg_x ? -1 : 1;
    end
    if (e2 < dlt_x) begin
      err   += dlt_x;
      cur_y += neg_y ? -1 : 1;
    end
    cur_x   = clamp16(longint'(cur_x));
    cur_y   = clamp16(longint'(cur_y));
    px.last = (cur_x == stop_x && cur_y == stop_y) || off_canvas(cur_x, cur_y);
    return 1'b1;
  endfunction

  task automatic send_item(input op_e op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input chk_e chk = ChkModel, input pix_t typed = '0);
    int   gap;
    bit   was_active;
    bit   due;
    pix_t px;
    gap = calm_in ? 0 : int'($urandom_range(0, 9));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    do @(posedge clk_i); while (!in_ch.ready);
    was_active = seg_active;
    due = trace_line(op, sx, sy, ex, ey, px);
    if (op == OpLoad || was_active) items_done++;
    case (chk)
      ChkModel: if (due) pixels_due.push_back(px);
      ChkPix:   pixels_due.push_back(typed);
      default:  ;
    endcase
  endtask

  task automatic send_step();
    send_item(OpStep, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  // sender pauses until every pixel due has arrived, then lets the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input int g, input int ox, input int oy);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgScale;
    cfg_wdata_i <= CfgDataW'(g);
    @(posedge clk_i);
    cfg_idx_i   <= CfgOriginX;
    cfg_wdata_i <= CfgDataW'(ox);
    @(posedge clk_i);
    cfg_idx_i   <= CfgOriginY;
    cfg_wdata_i <= CfgDataW'(oy);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain  = g;
    org_x = ox;
    org_y = oy;
  endtask

  task automatic random_segment();
    int r, span, sx, sy, ex, ey, n, t;
    calm_in = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      sx = $urandom_range(1, SwapBox);
      sy = $urandom_range(1, SwapBox);
      t  = $urandom_range(0, 99);
      span = (t < 85) ? 12 : ((t < 97) ? 120 : 700);
      ex = sx + int'($urandom_range(0, 2 * span)) - span;
      ey = sy + int'($urandom_range(0, 2 * span)) - span;
      n  = (ex > sx) ? ex - sx : sx - ex;
      t  = (ey > sy) ? ey - sy : sy - ey;
      if (t > n) n = t;
      n += $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
      // reversed order makes the first point fall outside the box now and then
      if ($urandom_range(0, 4) == 0) begin
        t = sx; sx = ex; ex = t;
        t = sy; sy = ey; ey = t;
      end
      send_item(OpLoad, screen_to_map(sx, org_x), screen_to_map(sy, org_y),
                screen_to_map(ex, org_x), screen_to_map(ey, org_y));
      repeat (n) send_step();
    end else if (r < 90) begin
      send_item(OpLoad, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom));
      repeat ($urandom_range(0, 4)) send_step();
    end else begin
      repeat ($urandom_range(1, 3)) send_step();
    end
  endtask

  // receiver: random stall per beat, bursts with none, and one long hold-off on request
  initial begin
    int   stall;
    int   burst_left;
    pix_t want;
    stall      = 0;
    burst_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: x=%0d y=%0d last=%0b",
                     out_ch.pixel_x, out_ch.pixel_y, out_ch.last);
        end else begin
          want = pixels_due.pop_front();
          if (want.pixel_x !== out_ch.pixel_x || want.pixel_y !== out_ch.pixel_y ||
              want.last !== out_ch.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel beat differs: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       want.pixel_x, want.pixel_y, want.last,
                       out_ch.pixel_x, out_ch.pixel_y, out_ch.last);
          end
        end
        if (burst_left > 0) burst_left--;
        else if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(10, 40);
        stall = (burst_left > 0) ? 0 : int'($urandom_range(0, 9));
      end
      if (hold_out) begin
        stall    = HoldCycles;
        hold_out = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    int p;
    int target;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OpStep;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumDir; i++)
      send_item(dir_tab[i].op, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey,
                dir_tab[i].chk, dir_tab[i].pix);

    // long line with the receiver held off, so the output buffer fills and input stalls
    settle();
    hold_out = 1'b1;
    calm_in  = 1'b1;
    send_item(OpLoad, 16'sd10, 16'sd10, 16'sd200, 16'sd60);
    repeat (150) send_step();
    settle();

    for (p = 0; p < NumPhases; p++) begin
      set_config(phase_gain[p], phase_ox[p], phase_oy[p]);
      target = items_done + PhaseItems;
      while (items_done < target) random_segment();
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pixels_due.size() == 0)
      $display("bresenham_line_pixel_generator: match");
    else
      $display("bresenham_line_pixel_generator: mismatch");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("bresenham_line_pixel_generator: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bres_pkg.sv
rtl/core/bres_in_if.sv
rtl/core/bres_out_if.sv
rtl/core/bres_scale.sv
rtl/core/bres_setup.sv
rtl/core/bres_walk.sv
rtl/core/bres_ofifo.sv
rtl/core/bresenham_line_pixel_generator.sv
sim/tb_bresenham_line_pixel_generator.sv
